### hw/rtl/msps_pkg.sv
// Shared types and constants for the multichannel servo pulse sequencer.
// No dependencies; every other file of the block imports this package.
package msps_pkg;

    localparam int MAX_CHANNELS = 8;
    localparam int CH_W         = 3;
    localparam int CNT_W        = 4;
    localparam int WIDTH_W      = 8;
    localparam int TICKS_W      = 16;
    localparam int CFG_IDX_W    = 8;
    localparam int CFG_DATA_W   = 16;

    // Pulse width is floor(angle * span / 180). The division by 180 is folded into a
    // scaled span: span * ceil(2^24 / 180). For products up to 180 * 255 the error
    // term stays below one unit of the shifted result, so the quotient is exact.
    localparam int RECIP_SHIFT   = 24;
    localparam int RECIP_W       = 17;
    localparam int SPAN_SCALED_W = 25;
    localparam int PROD_W        = 33;
    localparam logic [RECIP_W-1:0] RECIP_180 = 17'd93207;

    localparam logic [7:0] ANGLE_MAX = 8'd180;

    localparam logic [WIDTH_W-1:0] MIN_PULSE_RESET = 8'd125;
    localparam logic [7:0]         SPAN_RESET      = 8'd125;
    localparam logic [TICKS_W-1:0] SLOT_RESET      = 16'd312;
    localparam logic [CNT_W-1:0]   COUNT_RESET     = 4'd8;
    localparam logic [CNT_W-1:0]   COUNT_MAX       = CNT_W'(MAX_CHANNELS);
    localparam logic [SPAN_SCALED_W-1:0] SPAN_SCALED_RESET =
        SPAN_SCALED_W'(125 * 93207);
    localparam logic [WIDTH_W-1:0] WIDTH_RESET     = WIDTH_W'(SPAN_RESET / 2);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_PULSE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPAN      = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT      = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT     = 8'd3;

    // Item action codes.
    localparam logic ACT_TICK      = 1'b0;
    localparam logic ACT_SET_ANGLE = 1'b1;

    typedef struct packed {
        logic [WIDTH_W-1:0]       min_pulse;
        logic [SPAN_SCALED_W-1:0] span_scaled;
        logic [TICKS_W-1:0]       slot;
        logic [CNT_W-1:0]         eff_count;
    } t_cfg;

    typedef struct packed {
        logic          action;
        logic [CH_W-1:0] channel;
        logic [7:0]    angle;
    } t_item;

    typedef struct packed {
        logic [MAX_CHANNELS-1:0] pin_levels;
        logic [CH_W-1:0]         active_channel;
        logic                    in_high_phase;
    } t_result;

endpackage

### hw/rtl/msps_if.sv
// Handshake channels of the servo pulse sequencer: input items, results and
// configuration writes. Depends on msps_pkg for widths.
interface msps_item_if import msps_pkg::*; ();
    logic            valid;
    logic            ready;
    logic            action;
    logic [CH_W-1:0] channel;
    logic [7:0]      angle;

    modport source (output valid, action, channel, angle, input ready);
    modport sink   (input valid, action, channel, angle, output ready);
endinterface

interface msps_result_if import msps_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [MAX_CHANNELS-1:0] pin_levels;
    logic [CH_W-1:0]         active_channel;
    logic                    in_high_phase;

    modport source (output valid, pin_levels, active_channel, in_high_phase, input ready);
    modport sink   (input valid, pin_levels, active_channel, in_high_phase, output ready);
endinterface

interface msps_cfg_if import msps_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### hw/rtl/msps_width.sv
// Pulse width from a servo angle: saturates the angle and scales it by the span.
// Depends on msps_pkg.
module msps_width import msps_pkg::*; (
    input  logic [7:0]               i_angle,
    input  logic [SPAN_SCALED_W-1:0] i_span_scaled,
    output logic [WIDTH_W-1:0]       o_width
);
    logic [7:0]        angle_sat;
    logic [PROD_W-1:0] product;

    assign angle_sat = (i_angle > ANGLE_MAX) ? ANGLE_MAX : i_angle;
    assign product   = PROD_W'(angle_sat) * PROD_W'(i_span_scaled);
    assign o_width   = product[RECIP_SHIFT +: WIDTH_W];
endmodule

### hw/rtl/msps_cfg.sv
// Configuration registers of the servo pulse sequencer.
// Depends on msps_pkg and the msps_cfg_if channel.
module msps_cfg import msps_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    msps_cfg_if.sink   i_cfg,
    output t_cfg       o_cfg
);
    t_cfg             r_cfg;
    t_cfg             n_cfg;
    logic [CNT_W-1:0] count_raw;

    assign i_cfg.ready = 1'b1;
    assign count_raw   = i_cfg.data[CNT_W-1:0];

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_MIN_PULSE: n_cfg.min_pulse = i_cfg.data[WIDTH_W-1:0];
                CFG_SPAN: n_cfg.span_scaled =
                    SPAN_SCALED_W'(i_cfg.data[7:0]) * SPAN_SCALED_W'(RECIP_180);
                CFG_SLOT: n_cfg.slot = i_cfg.data[TICKS_W-1:0];
                CFG_COUNT: begin
                    // Zero behaves as one channel, too many as the full set.
                    if (count_raw == '0) begin
                        n_cfg.eff_count = CNT_W'(1);
                    end else if (count_raw > COUNT_MAX) begin
                        n_cfg.eff_count = COUNT_MAX;
                    end else begin
                        n_cfg.eff_count = count_raw;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_pulse   <= MIN_PULSE_RESET;
            r_cfg.span_scaled <= SPAN_SCALED_RESET;
            r_cfg.slot        <= SLOT_RESET;
            r_cfg.eff_count   <= COUNT_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;
endmodule

### hw/rtl/msps_seq.sv
// Sequencer state: width table, active slot, phase and tick countdown. Computes the
// state after one item and commits it on i_step. Depends on msps_pkg, msps_width.
module msps_seq import msps_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  logic    i_step,
    input  t_item   i_item,
    output t_result o_result
);
    logic [WIDTH_W-1:0] r_width [MAX_CHANNELS];
    logic [CH_W-1:0]    r_slot;
    logic               r_high;
    logic [TICKS_W-1:0] r_ticks;

    logic [CH_W-1:0]    n_slot;
    logic               n_high;
    logic [TICKS_W-1:0] n_ticks;

    logic [WIDTH_W-1:0] new_width;
    logic [WIDTH_W-1:0] cur_width;
    logic [TICKS_W-1:0] ticks_dec;
    logic [TICKS_W-1:0] cur_width_ext;
    logic [CNT_W-1:0]   slot_inc;
    logic               write_en;

    msps_width u_width (
        .i_angle       (i_item.angle),
        .i_span_scaled (i_cfg.span_scaled),
        .o_width       (new_width)
    );

    assign cur_width     = r_width[r_slot];
    assign cur_width_ext = TICKS_W'(cur_width);
    assign ticks_dec     = (r_ticks != '0) ? r_ticks - TICKS_W'(1) : '0;
    assign slot_inc      = CNT_W'(r_slot) + CNT_W'(1);
    assign write_en      = i_step && (i_item.action == ACT_SET_ANGLE)
                           && (CNT_W'(i_item.channel) < i_cfg.eff_count);

    always_comb begin
        n_slot  = r_slot;
        n_high  = r_high;
        n_ticks = r_ticks;
        if (i_item.action == ACT_TICK) begin
            n_ticks = ticks_dec;
            if (ticks_dec == '0) begin
                if (!r_high) begin
                    n_high  = 1'b1;
                    n_ticks = cur_width_ext + TICKS_W'(i_cfg.min_pulse);
                end else begin
                    n_high  = 1'b0;
                    n_ticks = (i_cfg.slot > cur_width_ext) ? i_cfg.slot - cur_width_ext
                                                           : '0;
                    // A count lowered below the active slot also wraps here.
                    n_slot  = (slot_inc >= i_cfg.eff_count) ? '0 : slot_inc[CH_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot  <= '0;
            r_high  <= 1'b0;
            r_ticks <= '0;
            for (int i = 0; i < MAX_CHANNELS; i++) begin
                r_width[i] <= WIDTH_RESET;
            end
        end else if (i_step) begin
            r_slot  <= n_slot;
            r_high  <= n_high;
            r_ticks <= n_ticks;
            if (write_en) begin
                r_width[i_item.channel] <= new_width;
            end
        end
    end

    assign o_result.pin_levels     = n_high ? (MAX_CHANNELS'(1) << n_slot) : '0;
    assign o_result.active_channel = n_slot;
    assign o_result.in_high_phase  = n_high;
endmodule

### hw/rtl/multichannel_servo_pulse_sequencer_core.sv
// Multichannel servo pulse sequencer: serves up to eight servo outputs in rotating
// time slots, one tick or set-angle item at a time, one result item per input item.
// It takes one item per clock cycle unless the result side stalls, through an input
// register and a result register, with all of the state update (countdown, phase,
// slot and width table write) done combinationally between them. Configuration writes
// are taken at any time, one per cycle; there is no clearing pass after reset.
// Depends on msps_pkg, msps_if, msps_cfg, msps_seq and msps_width.
module multichannel_servo_pulse_sequencer_core import msps_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    msps_item_if.sink     i_item,
    msps_cfg_if.sink      i_cfg,
    msps_result_if.source o_result
);
    logic    r_in_valid;
    t_item   r_in;
    logic    r_out_valid;
    t_result r_out;

    t_cfg    cfg;
    t_result next_result;
    logic    advance;

    assign advance      = r_in_valid && (!r_out_valid || o_result.ready);
    assign i_item.ready = !r_in_valid || advance;

    msps_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    msps_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_step   (advance),
        .i_item   (r_in),
        .o_result (next_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_item.ready) begin
                r_in_valid <= i_item.valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_in.action  <= i_item.action;
            r_in.channel <= i_item.channel;
            r_in.angle   <= i_item.angle;
        end
        if (advance) begin
            r_out <= next_result;
        end
    end

    assign o_result.valid          = r_out_valid;
    assign o_result.pin_levels     = r_out.pin_levels;
    assign o_result.active_channel = r_out.active_channel;
    assign o_result.in_high_phase  = r_out.in_high_phase;

    // At most one pin is driven, and only during the high phase.
    a_one_pin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> $onehot0(o_result.pin_levels))
        else $error("more than one servo pin high");

    a_pin_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> (o_result.in_high_phase == (o_result.pin_levels != '0)))
        else $error("pin levels disagree with phase");

    // An item leaving the input register always lands in the result register.
    a_advance_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("processed item lost its result");

    // A held input item with a free result slot must move on.
    a_no_stuck: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !r_out_valid) |-> advance)
        else $error("input register stalled with free output");
endmodule

### bench/multichannel_servo_pulse_sequencer_core_test.sv
// Self-checking bench for the multichannel servo pulse sequencer core.
// A built-in model of the slot rotation and pulse widths checks every result item.
// Depends on msps_pkg, the msps_* channel interfaces and the core itself.
module multichannel_servo_pulse_sequencer_core_test;
    import msps_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n;

    msps_item_if   item_ch ();
    msps_cfg_if    cfg_ch ();
    msps_result_if res_ch ();

    multichannel_servo_pulse_sequencer_core dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch),
        .i_cfg    (cfg_ch),
        .o_result (res_ch)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

    // Model of the sequencer: registers, width table, slot and countdown.
    logic [WIDTH_W-1:0] width_tab [MAX_CHANNELS];
    logic [CH_W-1:0]    cur_slot;
    logic               pulse_high;
    logic [TICKS_W-1:0] ticks_left;
    logic [7:0]         min_reg;
    logic [7:0]         span_reg;
    logic [TICKS_W-1:0] slot_reg;
    logic [CNT_W-1:0]   count_reg;

    t_item   pending_items [$];
    t_result pulse_forecast [$];
    int      items_total;
    int      results_done;
    int      mismatches;

    bit item_fired;
    bit res_fired;
    bit cfg_fired;
    bit send_calm;
    bit recv_calm;
    int send_wait;
    int recv_wait;
    bit hold_arm;
    bit hold_off;

    function automatic t_result step_sequencer(input t_item it);
        int      eff;
        int      deg;
        int      w;
        int      nxt;
        t_result r;
        eff = (count_reg == '0) ? 1 :
              ((int'(count_reg) > MAX_CHANNELS) ? MAX_CHANNELS : int'(count_reg));
        if (it.action == ACT_SET_ANGLE) begin
            deg = (it.angle > ANGLE_MAX) ? int'(ANGLE_MAX) : int'(it.angle);
            if (int'(it.channel) < eff)
                width_tab[it.channel] = WIDTH_W'(deg * int'(span_reg) / int'(ANGLE_MAX));
        end else begin
            if (ticks_left != '0)
                ticks_left = ticks_left - TICKS_W'(1);
            if (ticks_left == '0) begin
                w = int'(width_tab[cur_slot]);
                if (!pulse_high) begin
                    pulse_high = 1'b1;
                    ticks_left = TICKS_W'(w + int'(min_reg));
                end else begin
                    // The low time saturates at zero when the width exceeds the slot.
                    pulse_high = 1'b0;
                    ticks_left = (int'(slot_reg) > w) ? TICKS_W'(int'(slot_reg) - w) : '0;
                    nxt = int'(cur_slot) + 1;
                    if (nxt >= eff)
                        nxt = 0;
                    cur_slot = CH_W'(nxt);
                end
            end
        end
        r.pin_levels     = pulse_high ? (MAX_CHANNELS'(1) << cur_slot) : '0;
        r.active_channel = cur_slot;
        r.in_high_phase  = pulse_high;
        return r;
    endfunction

    always @(posedge i_clk) begin : servo_monitor
        t_item   seen;
        t_result got;
        t_result want;
        item_fired <= i_rst_n && item_ch.valid && item_ch.ready;
        res_fired  <= i_rst_n && res_ch.valid && res_ch.ready;
        cfg_fired  <= i_rst_n && cfg_ch.valid && cfg_ch.ready;
        if (i_rst_n) begin
            if (cfg_ch.valid && cfg_ch.ready) begin
                case (cfg_ch.index)
                    CFG_MIN_PULSE: min_reg   = cfg_ch.data[7:0];
                    CFG_SPAN:      span_reg  = cfg_ch.data[7:0];
                    CFG_SLOT:      slot_reg  = cfg_ch.data;
                    CFG_COUNT:     count_reg = cfg_ch.data[CNT_W-1:0];
                    default: ;  // Writes to unknown indexes have no effect.
                endcase
            end
            if (item_ch.valid && item_ch.ready) begin
                seen.action  = item_ch.action;
                seen.channel = item_ch.channel;
                seen.angle   = item_ch.angle;
                pulse_forecast.push_back(step_sequencer(seen));
            end
            if (res_ch.valid && res_ch.ready) begin
                got.pin_levels     = res_ch.pin_levels;
                got.active_channel = res_ch.active_channel;
                got.in_high_phase  = res_ch.in_high_phase;
                results_done++;
                if (pulse_forecast.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result item: pins=%h channel=%0d high=%0b",
                                 got.pin_levels, got.active_channel, got.in_high_phase);
                end else begin
                    want = pulse_forecast.pop_front();
                    if (got.pin_levels !== want.pin_levels ||
                        got.active_channel !== want.active_channel ||
                        got.in_high_phase !== want.in_high_phase) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result %0d: expected pins=%h channel=%0d high=%0b, ",
                                     results_done, want.pin_levels,
                                     want.active_channel, want.in_high_phase,
                                     "got pins=%h channel=%0d high=%0b",
                                     got.pin_levels, got.active_channel,
                                     got.in_high_phase);
                    end
                end
            end
        end
    end

    always @(negedge i_clk) begin : item_driver
        t_item nxt_item;
        if (!i_rst_n) begin
            item_ch.valid <= 1'b0;
        end else if (item_ch.valid && !item_fired) begin
            // The current item is still waiting to be taken.
        end else if (send_wait > 0) begin
            item_ch.valid <= 1'b0;
            send_wait     <= send_wait - 1;
        end else if (pending_items.size() != 0) begin
            nxt_item = pending_items.pop_front();
            item_ch.valid   <= 1'b1;
            item_ch.action  <= nxt_item.action;
            item_ch.channel <= nxt_item.channel;
            item_ch.angle   <= nxt_item.angle;
            if ($urandom_range(0, 47) == 0)
                send_calm = !send_calm;
            send_wait <= send_calm ? 0 : $urandom_range(0, 11);
        end else begin
            item_ch.valid <= 1'b0;
        end
    end

    always @(negedge i_clk) begin : result_sink
        int w;
        if (!i_rst_n || hold_off) begin
            res_ch.ready <= 1'b0;
        end else if (res_fired) begin
            if ($urandom_range(0, 47) == 0)
                recv_calm = !recv_calm;
            w = recv_calm ? 0 : $urandom_range(0, 11);
            res_ch.ready <= (w == 0);
            recv_wait    <= (w == 0) ? 0 : w - 1;
        end else if (recv_wait > 0) begin
            res_ch.ready <= 1'b0;
            recv_wait    <= recv_wait - 1;
        end else begin
            res_ch.ready <= 1'b1;
        end
    end

    // One long stall of the result side while items keep coming in.
    initial begin : result_hold_off
        hold_off = 1'b0;
        wait (hold_arm);
        @(posedge i_clk);
        hold_off = 1'b1;
        repeat (400) @(posedge i_clk);
        hold_off = 1'b0;
    end

    function automatic void queue_item(input logic act, input int ch, input int ang);
        t_item it;
        it.action  = act;
        it.channel = CH_W'(ch);
        it.angle   = 8'(ang);
        pending_items.push_back(it);
        items_total++;
    endfunction

    function automatic int pick_setting(input int top, input int usual);
        int r;
        r = $urandom_range(0, 5);
        if (r == 0)
            return 0;
        if (r == 1)
            return top;
        return $urandom_range(0, usual);
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data  = val;
        @(negedge i_clk);
        while (!cfg_fired)
            @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    // Unused upper data bits are filled at random; the block must drop them.
    task automatic program_servo(input int minp, input int span, input int slot,
                                 input int cnt);
        write_reg(CFG_MIN_PULSE, {8'($urandom), 8'(minp)});
        write_reg(CFG_SPAN, {8'($urandom), 8'(span)});
        write_reg(CFG_SLOT, CFG_DATA_W'(slot));
        write_reg(CFG_COUNT, {12'($urandom), CNT_W'(cnt)});
        if ($urandom_range(0, 2) == 0)
            write_reg(CFG_IDX_W'($urandom_range(int'(CFG_COUNT) + 1, (1 << CFG_IDX_W) - 1)),
                      CFG_DATA_W'($urandom));
    endtask

    // Every item yields one result, so all results in means the block is idle.
    task automatic drain_items();
        while (results_done < items_total)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    initial begin : stimulus
        int phase;
        int n;
        int cnt;
        i_rst_n         = 1'b0;
        item_ch.valid   = 1'b0;
        item_ch.action  = ACT_TICK;
        item_ch.channel = '0;
        item_ch.angle   = '0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.index    = CFG_MIN_PULSE;
        cfg_ch.data     = '0;
        res_ch.ready    = 1'b0;
        min_reg    = MIN_PULSE_RESET;
        span_reg   = SPAN_RESET;
        slot_reg   = SLOT_RESET;
        count_reg  = COUNT_RESET;
        cur_slot   = '0;
        pulse_high = 1'b0;
        ticks_left = '0;
        for (n = 0; n < MAX_CHANNELS; n++)
            width_tab[n] = WIDTH_RESET;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Angle saturation and the 90 degree default with the reset settings.
        queue_item(ACT_SET_ANGLE, 7, 255);
        queue_item(ACT_SET_ANGLE, 6, 181);
        queue_item(ACT_SET_ANGLE, 3, 90);
        queue_item(ACT_SET_ANGLE, 0, 0);
        drain_items();

        // Two channels, no minimum pulse and a zero slot: zero-length phases,
        // widths above the slot, and channels beyond the count.
        program_servo(0, 255, 0, 2);
        queue_item(ACT_SET_ANGLE, 5, 100);
        queue_item(ACT_SET_ANGLE, 0, 0);
        queue_item(ACT_SET_ANGLE, 1, 1);
        queue_item(ACT_SET_ANGLE, 4, 180);
        repeat (6) queue_item(ACT_TICK, 0, 0);
        queue_item(ACT_SET_ANGLE, 0, 180);
        repeat (4) queue_item(ACT_TICK, 0, 0);
        queue_item(ACT_SET_ANGLE, 1, 255);

        for (phase = 0; phase < 10; phase++) begin
            drain_items();
            case (phase)
                0: program_servo($urandom_range(0, 6), $urandom_range(0, 12),
                                 $urandom_range(0, 20), 8);
                // Lowering the count below the active channel forces a wrap.
                1: program_servo($urandom_range(0, 6), $urandom_range(0, 12),
                                 $urandom_range(0, 20), int'(cur_slot));
                2: program_servo(0, 0, 0, 0);
                3: program_servo(255, 255, 65535, 15);
                default: begin
                    cnt = ($urandom_range(0, 3) == 0) ? int'(cur_slot) : $urandom_range(0, 15);
                    program_servo(pick_setting(255, 6), pick_setting(255, 12),
                                  pick_setting(65535, 20), cnt);
                end
            endcase
            if (phase == 5)
                hold_arm = 1'b1;
            for (n = 0; n < 200; n++) begin
                if ($urandom_range(0, 3) == 0)
                    queue_item(ACT_SET_ANGLE, $urandom_range(0, 7), $urandom_range(0, 255));
                else
                    queue_item(ACT_TICK, $urandom_range(0, 7), $urandom_range(0, 255));
            end
        end

        drain_items();
        if (mismatches == 0 && pulse_forecast.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

### files.f
hw/rtl/msps_pkg.sv
hw/rtl/msps_if.sv
hw/rtl/msps_width.sv
hw/rtl/msps_cfg.sv
hw/rtl/msps_seq.sv
hw/rtl/multichannel_servo_pulse_sequencer_core.sv
bench/multichannel_servo_pulse_sequencer_core_test.sv
